// File: rtl/core/cspg_pkg.sv
// Package with shared types, constants and coefficient tables for the cosine spacing generator.
`default_nettype none

package cspg_pkg;

  // Fixed-point formats: span length in Q16.16, blend factor in Q1.16, internal unit values in Q1.30.
  localparam int FRAC_BITS   = 16;
  localparam int MAX_POINTS  = 1024;
  localparam int UNIT_FRAC   = 30;
  localparam int UNIT_W      = UNIT_FRAC + 1;
  localparam int IDX_W       = 10;
  localparam int CNT_W       = 11;
  localparam int SPAN_W      = 32;
  localparam int FACTOR_W    = FRAC_BITS + 1;

  localparam logic [UNIT_W-1:0]   UNIT_ONE  = UNIT_W'(1) << UNIT_FRAC;
  localparam logic [UNIT_W-1:0]   HALF_PI   = 31'd1686629713;
  localparam logic [FACTOR_W-1:0] FACTOR_ONE = FACTOR_W'(1) << FRAC_BITS;

  // Divider: one quotient bit per step, four steps per pipeline stage.
  localparam int DIV_STEPS      = UNIT_W;
  localparam int DIV_PER_STAGE  = 4;
  localparam int DIV_STAGES     = (DIV_STEPS + DIV_PER_STAGE - 1) / DIV_PER_STAGE;

  // Taylor series evaluation in Horner form.
  localparam int NUM_HORNER = 6;

  // Cycles from an accepted start to its done strobe.
  localparam int LATENCY = 1 + DIV_STAGES + 3 + 3 * NUM_HORNER + 1 + 5;

  // Spacing mode codes.
  localparam logic [1:0] MODE_LEFT   = 2'd0;
  localparam logic [1:0] MODE_CENTER = 2'd1;
  localparam logic [1:0] MODE_RIGHT  = 2'd2;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_POINT_COUNT = 2'd0,
    REG_BLEND       = 2'd1,
    REG_MODE        = 2'd2,
    REG_SPAN        = 2'd3
  } cfg_reg_t;

  // Data that rides alongside the arithmetic.
  typedef struct packed {
    logic              last;
    logic [UNIT_W-1:0] t30;
  } side_t;

  // Long division state.
  typedef struct packed {
    logic              last;
    logic [IDX_W-1:0]  rem;
    logic [UNIT_W-1:0] low;
    logic [UNIT_W-1:0] quo;
  } div_t;

  // Sine evaluation state.
  typedef struct packed {
    side_t             side;
    logic              u_zero;
    logic              u_one;
    logic [UNIT_W-1:0] x;
    logic [31:0]       x2;
    logic [UNIT_W-1:0] term;
  } hstate_t;

  // Horner divisors, in evaluation order.
  function automatic logic [7:0] horner_k(input int idx);
    logic [7:0] k;
    unique case (idx)
      0:       k = 8'd156;
      1:       k = 8'd110;
      2:       k = 8'd72;
      3:       k = 8'd42;
      4:       k = 8'd20;
      default: k = 8'd6;
    endcase
    return k;
  endfunction

  // floor(2^32 / k) for each Horner divisor.
  function automatic logic [31:0] horner_recip(input int idx);
    logic [31:0] m;
    unique case (idx)
      0:       m = 32'd27531841;
      1:       m = 32'd39045157;
      2:       m = 32'd59652323;
      3:       m = 32'd102261126;
      4:       m = 32'd214748364;
      default: m = 32'd715827882;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/cosine_spacing_point_generator_top.sv
// Top level of the cosine spacing point generator: registers, front end and blend pipeline.
//
// Usage: raise start with point_index; the item is taken at any rising edge where start
// is high and busy is low. busy stays low, so an index can be given in every cycle.
// Each index yields one result: done is high for one cycle with point_position
// (unsigned Q16.16, saturated) and is_last_point. Results come out in input order.
// The path from accepting start to done runs through one input register, eight
// divider stages of up to four quotient bits each, the sine evaluation (six Horner
// steps of three stages each), and five stages of mode select, blend and span scaling.
// Throughput is one item per cycle; every stage is a plain register with a valid bit.
// The receiver cannot hold results off; done is a strobe and nothing waits.
// Configuration: cfg_we writes cfg_data into register cfg_index at the clock edge
// (0 point count, 1 blend factor, 2 spacing mode, 3 span length). Write only while
// no item is in flight, since later stages read the registers directly.
// Synchronous reset empties the pipeline and loads point count 2, blend factor 1.0,
// center mode and span 1.0.
`default_nettype none

module cosine_spacing_point_generator_top import cspg_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [IDX_W-1:0]  point_index,
  output logic              done,
  output logic [SPAN_W-1:0] point_position,
  output logic              is_last_point,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data
);

  logic [CNT_W-1:0]    point_count;
  logic [FACTOR_W-1:0] blend_factor;
  logic [1:0]          spacing_mode;
  logic [SPAN_W-1:0]   span_length;

  logic [CNT_W-1:0]    n_eff;
  logic [IDX_W-1:0]    div_d;
  logic [IDX_W-1:0]    idx_c;
  logic                in_valid, in_last;
  logic [IDX_W-1:0]    in_idx;

  logic                div_valid;
  side_t               div_side;
  logic [UNIT_W-1:0]   sine_u;

  logic                sine_valid;
  logic [UNIT_W-1:0]   sine_s;
  side_t               sine_side;

  logic [61:0]         sq_mul;
  logic                c_valid;
  logic [UNIT_W-1:0]   cos_v;
  side_t               c_side;

  logic [FACTOR_W-1:0] f_eff, f_rest;
  logic                b1_valid, b1_last;
  logic [47:0]         p_cos, p_lin;
  logic [48:0]         mix_sum;
  logic [32:0]         mix_raw;
  logic                b2_valid, b2_last;
  logic [UNIT_W-1:0]   mix;

  logic                m_valid, m_last;
  logic [62:0]         span_prod;
  logic [62:0]         pos_round;

  assign busy = 1'b0;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count  <= CNT_W'(2);
      blend_factor <= FACTOR_ONE;
      spacing_mode <= MODE_CENTER;
      span_length  <= SPAN_W'(FACTOR_ONE);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_POINT_COUNT: point_count  <= cfg_data[CNT_W-1:0];
        REG_BLEND:       blend_factor <= cfg_data[FACTOR_W-1:0];
        REG_MODE:        spacing_mode <= cfg_data[1:0];
        REG_SPAN:        span_length  <= cfg_data[SPAN_W-1:0];
        default:         ;
      endcase
    end
  end

  // Grid size limits and index clamp.
  always_comb begin
    if (point_count < CNT_W'(2)) begin
      n_eff = CNT_W'(2);
    end else if (point_count > CNT_W'(MAX_POINTS)) begin
      n_eff = CNT_W'(MAX_POINTS);
    end else begin
      n_eff = point_count;
    end
  end

  assign div_d = IDX_W'(n_eff - CNT_W'(1));
  assign idx_c = (point_index > div_d) ? div_d : point_index;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
    in_idx  <= idx_c;
    in_last <= (idx_c == div_d);
  end

  // Normalized position t.
  cspg_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .idx       (in_idx),
    .in_last   (in_last),
    .divisor   (div_d),
    .out_valid (div_valid),
    .out_side  (div_side)
  );

  // Left mode evaluates the sine at the mirrored position.
  assign sine_u = (spacing_mode == MODE_LEFT) ? UNIT_ONE - div_side.t30 : div_side.t30;

  cspg_sine u_sine (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (div_valid),
    .u         (sine_u),
    .in_side   (div_side),
    .out_valid (sine_valid),
    .s         (sine_s),
    .out_side  (sine_side)
  );

  // Cosine part by mode; mode three counts as center.
  assign sq_mul = 62'(sine_s) * 62'(sine_s);

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else begin
      c_valid <= sine_valid;
    end
    c_side <= sine_side;
    if (spacing_mode == MODE_LEFT) begin
      cos_v <= UNIT_ONE - sine_s;
    end else if (spacing_mode == MODE_RIGHT) begin
      cos_v <= sine_s;
    end else begin
      cos_v <= sq_mul[60:30];
    end
  end

  // Blend of cosine and linear parts.
  assign f_eff  = (blend_factor > FACTOR_ONE) ? FACTOR_ONE : blend_factor;
  assign f_rest = FACTOR_ONE - f_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
    end else begin
      b1_valid <= c_valid;
    end
    b1_last <= c_side.last;
    p_cos   <= 48'(f_eff) * 48'(cos_v);
    p_lin   <= 48'(f_rest) * 48'(c_side.t30);
  end

  assign mix_sum = 49'(p_cos) + 49'(p_lin) + (49'(1) << (FRAC_BITS - 1));
  assign mix_raw = mix_sum[48:FRAC_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      b2_valid <= 1'b0;
    end else begin
      b2_valid <= b1_valid;
    end
    b2_last <= b1_last;
    mix     <= (mix_raw > 33'(UNIT_ONE)) ? UNIT_ONE : mix_raw[UNIT_W-1:0];
  end

  // Scaling by the span length.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else begin
      m_valid <= b2_valid;
    end
    m_last    <= b2_last;
    span_prod <= 63'(span_length) * 63'(mix);
  end

  // Rounding, saturation and the result register.
  assign pos_round = span_prod + (63'(1) << (UNIT_FRAC - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= m_valid;
    end
    is_last_point  <= m_last;
    point_position <= pos_round[62] ? '1 : pos_round[61:30];
  end

  // Every result traces back to a start accepted a fixed time earlier.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LATENCY))
    else $error("done without a matching start");

  // The normalized position never exceeds one.
  a_t_range: assert property (@(posedge clk) disable iff (rst)
    div_valid |-> (div_side.t30 <= UNIT_ONE))
    else $error("divider quotient above one");

  // The sine stays within the unit range.
  a_sine_range: assert property (@(posedge clk) disable iff (rst)
    sine_valid |-> (sine_s <= UNIT_ONE))
    else $error("sine result above one");

endmodule

`default_nettype wire

// File: rtl/core/cspg_div.sv
// Pipelined restoring divider that forms t = i/(n-1) in Q1.30 with rounding.
`default_nettype none

module cspg_div import cspg_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [IDX_W-1:0] idx,
  input  logic             in_last,
  input  logic [IDX_W-1:0] divisor,
  output logic             out_valid,
  output side_t            out_side
);

  div_t stage [DIV_STAGES+1];
  logic vld   [DIV_STAGES+1];

  // A group of division steps; steps past the last quotient bit pass through.
  function automatic div_t div_steps(input div_t s, input logic [IDX_W-1:0] d, input int g);
    div_t        r;
    logic [IDX_W:0] r2;
    r = s;
    for (int j = 0; j < DIV_PER_STAGE; j++) begin
      if (g * DIV_PER_STAGE + j < DIV_STEPS) begin
        r2    = {r.rem, r.low[UNIT_W-1]};
        r.low = {r.low[UNIT_W-2:0], 1'b0};
        if (r2 >= {1'b0, d}) begin
          r.rem = IDX_W'(r2 - {1'b0, d});
          r.quo = {r.quo[UNIT_W-2:0], 1'b1};
        end else begin
          r.rem = r2[IDX_W-1:0];
          r.quo = {r.quo[UNIT_W-2:0], 1'b0};
        end
      end
    end
    return r;
  endfunction

  // Dividend is (i << 30) + d/2; its top bits are i/2, already below d.
  assign vld[0]        = in_valid;
  assign stage[0].last = in_last;
  assign stage[0].rem  = {1'b0, idx[IDX_W-1:1]};
  assign stage[0].low  = {idx[0], 21'b0, divisor[IDX_W-1:1]};
  assign stage[0].quo  = '0;

  // Division stages.
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else begin
        vld[g+1] <= vld[g];
      end
      stage[g+1] <= div_steps(stage[g], divisor, g);
    end
  end

  assign out_valid     = vld[DIV_STAGES];
  assign out_side.last = stage[DIV_STAGES].last;
  assign out_side.t30  = stage[DIV_STAGES].quo;

endmodule

`default_nettype wire

// File: rtl/core/cspg_horner.sv
// One Horner step of the sine series: term = 1 - (x2 * term) / k, over three stages.
`default_nettype none

module cspg_horner import cspg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  hstate_t     in_st,
  input  logic [7:0]  k,
  input  logic [31:0] recip,
  output logic        out_valid,
  output hstate_t     out_st
);

  logic        v1, v2;
  hstate_t     st1, st2;
  hstate_t     out_st_next;
  logic [31:0] prod1, prod2, q0;
  logic [62:0] mul1;
  logic [63:0] mul2;
  logic [39:0] q0k, rem;
  logic [31:0] q;

  assign mul1 = 63'(in_st.x2) * 63'(in_st.term);
  assign mul2 = 64'(prod1) * 64'(recip);

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  // Product, reciprocal estimate of the quotient, then a one-step correction.
  assign q0k = 40'(q0) * 40'(k);
  assign rem = {8'b0, prod2} - q0k;
  assign q   = (rem >= 40'(k)) ? q0 + 32'd1 : q0;

  // The side data moves on with the new term.
  always_comb begin
    out_st_next      = st2;
    out_st_next.term = UNIT_ONE - q[UNIT_W-1:0];
  end

  always_ff @(posedge clk) begin
    st1    <= in_st;
    prod1  <= mul1[61:30];
    st2    <= st1;
    prod2  <= prod1;
    q0     <= mul2[63:32];
    out_st <= out_st_next;
  end

endmodule

`default_nettype wire

// File: rtl/core/cspg_sine.sv
// Quarter-wave sine sin(pi/2 * u) in Q1.30 through a pipelined Taylor series.
`default_nettype none

module cspg_sine import cspg_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [UNIT_W-1:0] u,
  input  side_t             in_side,
  output logic              out_valid,
  output logic [UNIT_W-1:0] s,
  output side_t             out_side
);

  logic              va, vb, vc;
  logic [UNIT_W-1:0] ua;
  side_t             side_a;
  hstate_t           hb;
  hstate_t           h0_next;
  hstate_t           h     [NUM_HORNER+1];
  logic              hv    [NUM_HORNER+1];
  logic [61:0]       xmul, x2mul, smul;
  logic [UNIT_W-1:0] sv;

  assign xmul  = 62'(ua) * 62'(HALF_PI);
  assign x2mul = 62'(hb.x) * 62'(hb.x);

  // Valid bits of the front stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else begin
      va <= in_valid;
      vb <= va;
      vc <= vb;
    end
  end

  // The square of the angle joins the state of the first Horner step.
  always_comb begin
    h0_next    = hb;
    h0_next.x2 = x2mul[61:30];
  end

  // Argument scaling to radians, then the square of the angle.
  always_ff @(posedge clk) begin
    ua        <= u;
    side_a    <= in_side;
    hb.side   <= side_a;
    hb.u_zero <= (ua == '0);
    hb.u_one  <= (ua >= UNIT_ONE);
    hb.x      <= xmul[60:30];
    hb.x2     <= '0;
    hb.term   <= UNIT_ONE;
    h[0]      <= h0_next;
  end

  assign hv[0] = vc;

  // Horner steps.
  for (genvar i = 0; i < NUM_HORNER; i++) begin : g_horner
    cspg_horner u_horner (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (hv[i]),
      .in_st     (h[i]),
      .k         (horner_k(i)),
      .recip     (horner_recip(i)),
      .out_valid (hv[i+1]),
      .out_st    (h[i+1])
    );
  end

  // Final multiply by x, clamp and exact endpoints.
  assign smul = 62'(h[NUM_HORNER].x) * 62'(h[NUM_HORNER].term);
  assign sv   = smul[60:30];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= hv[NUM_HORNER];
    end
    out_side <= h[NUM_HORNER].side;
    if (h[NUM_HORNER].u_zero) begin
      s <= '0;
    end else if (h[NUM_HORNER].u_one || sv > UNIT_ONE) begin
      s <= UNIT_ONE;
    end else begin
      s <= sv;
    end
  end

endmodule

`default_nettype wire
